[hw/rtl/sis_pkg.sv]
// ----------------------------------------------------------------------------
// sis_pkg: shared types for the stable insertion sorter
// Entry layout of one sorting cell and the control word that drives the chain.
// ----------------------------------------------------------------------------
package sis_pkg;

   localparam int KEY_W = 16;
   localparam int TAG_W = 8;

   typedef struct packed {
      logic [TAG_W-1:0]        tag;
      logic signed [KEY_W-1:0] key;
   } entry_type;

   // insert: a new entry is placed this cycle; shift: chain moves toward cell 0
   typedef struct packed {
      logic insert;
      logic shift;
   } chain_ctrl_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

endpackage

[hw/rtl/sis_cell.sv]
// ----------------------------------------------------------------------------
// sis_cell: one slot of the insertion chain
// Holds one entry. On insert it keeps, takes its left neighbor or takes the
// new entry; on drain it takes its right neighbor.
// ----------------------------------------------------------------------------
module sis_cell (
   input  logic                    clock,
   input  sis_pkg::chain_ctrl_type ctrl,
   input  sis_pkg::entry_type      new_entry,
   input  sis_pkg::entry_type      left_entry,
   input  logic                    left_gt,
   input  logic                    left_occ,
   input  sis_pkg::entry_type      right_entry,
   input  logic                    occ,
   output sis_pkg::entry_type      cell_entry,
   output logic                    cell_gt
);

   sis_pkg::entry_type entry_ff;
   sis_pkg::entry_type entry_in;
   logic               take;

   // strict greater-than keeps equal keys in arrival order
   assign cell_gt = occ && (entry_ff.key > new_entry.key);
   assign take    = ctrl.insert && (cell_gt || !occ) && left_occ;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift) begin
         entry_in = right_entry;
      end else if (take) begin
         entry_in = left_gt ? left_entry : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign cell_entry = entry_ff;

endmodule

[hw/rtl/stable_insertion_sorter.sv]
// ----------------------------------------------------------------------------
// stable_insertion_sorter: stable ascending sort of a list of keyed items
// Chain of cells kept in key order; the last item of a list flushes it.
// ----------------------------------------------------------------------------
// Input stream (req_*): one item per transfer, tdata = {tag, key}, tlast marks
// the final item of a list. Items are inserted into the chain at one per
// cycle while the block is loading: every cell compares its key against the
// incoming key in parallel and the larger entries move up by one cell.
// Equal keys stay in arrival order. Once CAPACITY items are held, further
// items of the list are dropped and the overflow flag (rsp_tuser) is raised
// on every result of that run. After the tlast transfer the block stops
// accepting input and drains the chain through cell 0, one result per cycle
// while rsp_tready allows, N results for N stored items. rsp_tlast marks the
// final result; input is accepted again from the cycle in which that final
// result is presented.
// A stalled rsp_tready holds the output register and freezes the drain;
// input is not taken while a run is draining.
// Reset (synchronous, active high) empties the chain, clears the overflow
// flag and the output valid; cell contents are not cleared.
// ----------------------------------------------------------------------------
module stable_insertion_sorter #(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] sort_key, [23:16] item_tag
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] out_key, [23:16] out_tag
   output logic        rsp_tlast,   // last_out
   output logic [0:0]  rsp_tuser    // [0] overflow
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   sis_pkg::state_type      state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    drop_ff, drop_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   sis_pkg::entry_type      rsp_entry_ff, rsp_entry_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   sis_pkg::chain_ctrl_type ctrl;
   sis_pkg::entry_type      new_entry;
   sis_pkg::entry_type      cell_entry [CAPACITY];
   logic [CAPACITY-1:0]     cell_gt;
   logic [CAPACITY-1:0]     cell_occ;
   logic                    req_xfer;
   logic                    full;
   logic                    out_free;

   assign new_entry.key = req_tdata[15:0];
   assign new_entry.tag = req_tdata[23:16];
   assign req_tready    = (state_ff == sis_pkg::ST_LOAD);
   assign req_xfer      = req_tvalid && req_tready;
   assign full          = (count_ff == CNT_W'(CAPACITY));
   assign out_free      = !rsp_valid_ff || rsp_tready;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         assign cell_occ[gi] = (count_ff > CNT_W'(gi));
         if (gi == 0) begin : g_head
            sis_cell u_cell (
               .clock       (clock),
               .ctrl        (ctrl),
               .new_entry   (new_entry),
               .left_entry  (new_entry),
               .left_gt     (1'b0),
               .left_occ    (1'b1),
               .right_entry (cell_entry[gi+1]),
               .occ         (cell_occ[gi]),
               .cell_entry  (cell_entry[gi]),
               .cell_gt     (cell_gt[gi])
            );
         end else if (gi == CAPACITY - 1) begin : g_tail
            sis_cell u_cell (
               .clock       (clock),
               .ctrl        (ctrl),
               .new_entry   (new_entry),
               .left_entry  (cell_entry[gi-1]),
               .left_gt     (cell_gt[gi-1]),
               .left_occ    (cell_occ[gi-1]),
               .right_entry (cell_entry[gi]),
               .occ         (cell_occ[gi]),
               .cell_entry  (cell_entry[gi]),
               .cell_gt     (cell_gt[gi])
            );
         end else begin : g_mid
            sis_cell u_cell (
               .clock       (clock),
               .ctrl        (ctrl),
               .new_entry   (new_entry),
               .left_entry  (cell_entry[gi-1]),
               .left_gt     (cell_gt[gi-1]),
               .left_occ    (cell_occ[gi-1]),
               .right_entry (cell_entry[gi+1]),
               .occ         (cell_occ[gi]),
               .cell_entry  (cell_entry[gi]),
               .cell_gt     (cell_gt[gi])
            );
         end
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_entry_in = rsp_entry_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ctrl.insert  = 1'b0;
      ctrl.shift   = 1'b0;
      unique case (state_ff)
         sis_pkg::ST_LOAD: begin
            if (req_xfer) begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  ctrl.insert = 1'b1;
                  count_in    = count_ff + CNT_W'(1);
               end
               if (req_tlast) begin
                  state_in = sis_pkg::ST_DRAIN;
               end
            end
         end
         sis_pkg::ST_DRAIN: begin
            if (out_free) begin
               ctrl.shift   = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_entry_in = cell_entry[0];
               rsp_last_in  = (count_ff == CNT_W'(1));
               rsp_ovf_in   = drop_ff;
               count_in     = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = sis_pkg::ST_LOAD;
                  drop_in  = 1'b0;
               end
            end
         end
         default: state_in = sis_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sis_pkg::ST_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_entry_ff <= rsp_entry_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata[15:0]  = rsp_entry_ff.key;
   assign rsp_tdata[23:16] = rsp_entry_ff.tag;
   assign rsp_tlast        = rsp_last_ff;
   assign rsp_tuser[0]     = rsp_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("item count above capacity");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == sis_pkg::ST_DRAIN |-> count_ff != '0)
      else $error("draining an empty chain");

   a_last_starts_drain: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tlast |=> state_ff == sis_pkg::ST_DRAIN)
      else $error("end of list did not start the drain");

   // loading the final result leaves the chain empty and ready for input
   a_tlast_empties: assert property (@(posedge clock) disable iff (reset)
      ctrl.shift && rsp_last_in |=> state_ff == sis_pkg::ST_LOAD && count_ff == '0)
      else $error("final result while items remain");

endmodule
